FILE: design/utf8_decoder_core_macros.svh
// Assertion macros used by the checker file of the UTF-8 decoder.
`ifndef UTF8_DECODER_CORE_MACROS_SVH
`define UTF8_DECODER_CORE_MACROS_SVH

// Plain property, sampled on clk_i and switched off while rst_ni is low.
`define UTF8D_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same-cycle implication, sampled on clk_i and switched off while rst_ni is low.
`define UTF8D_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i and switched off while rst_ni is low.
`define UTF8D_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/utf8d_pkg.sv
package utf8d_pkg;

  localparam int unsigned ByteW      = 8;
  localparam int unsigned CodePointW = 21;
  localparam int unsigned CountW     = 3;

  localparam logic [CodePointW-1:0] MaxCodePoint   = 21'h10FFFF;
  localparam logic [CodePointW-1:0] Min2ByteValue  = 21'h000080;
  localparam logic [CodePointW-1:0] Min3ByteValue  = 21'h000800;
  localparam logic [CodePointW-1:0] Min4ByteValue  = 21'h010000;
  localparam logic [CodePointW-1:0] SurrogateLow   = 21'h00D800;
  localparam logic [CodePointW-1:0] SurrogateHigh  = 21'h00DFFF;
  localparam logic [CodePointW-1:0] MaxSingleByte  = 21'h0000FF;

  localparam logic [CountW-1:0] Len1 = 3'd1;
  localparam logic [CountW-1:0] Len2 = 3'd2;
  localparam logic [CountW-1:0] Len3 = 3'd3;
  localparam logic [CountW-1:0] Len4 = 3'd4;

  typedef struct packed {
    logic [CodePointW-1:0] code_point;
    logic [CountW-1:0]     consumed;
  } result_t;

  function automatic logic is_cont(input logic [ByteW-1:0] b);
    return b[7:6] == 2'b10;
  endfunction

  // Decodes one four-byte window. All three multi-byte forms are checked side
  // by side; at most one of them can match the lead byte.
  function automatic result_t decode(input logic [ByteW-1:0]  lead,
                                     input logic [ByteW-1:0]  b2,
                                     input logic [ByteW-1:0]  b3,
                                     input logic [ByteW-1:0]  b4,
                                     input logic [CountW-1:0] left);
    logic [CountW-1:0]     avail;
    logic [CodePointW-1:0] v2;
    logic [CodePointW-1:0] v3;
    logic [CodePointW-1:0] v4;
    logic                  ok2;
    logic                  ok3;
    logic                  ok4;
    result_t               res;
    avail = (left > Len4) ? Len4 : left;
    v2 = {10'd0, lead[4:0], b2[5:0]};
    v3 = {5'd0, lead[3:0], b2[5:0], b3[5:0]};
    v4 = {lead[2:0], b2[5:0], b3[5:0], b4[5:0]};
    ok2 = (lead[7:5] == 3'b110) && (avail >= Len2) && is_cont(b2) &&
          (v2 >= Min2ByteValue);
    ok3 = (lead[7:4] == 4'b1110) && (avail >= Len3) && is_cont(b2) &&
          is_cont(b3) && (v3 >= Min3ByteValue) &&
          !((v3 >= SurrogateLow) && (v3 <= SurrogateHigh));
    ok4 = (lead[7:3] == 5'b11110) && (avail == Len4) && is_cont(b2) &&
          is_cont(b3) && is_cont(b4) && (v4 >= Min4ByteValue) &&
          (v4 <= MaxCodePoint);
    if (ok2) begin
      res.code_point = v2;
      res.consumed   = Len2;
    end else if (ok3) begin
      res.code_point = v3;
      res.consumed   = Len3;
    end else if (ok4) begin
      res.code_point = v4;
      res.consumed   = Len4;
    end else begin
      res.code_point = {{(CodePointW-ByteW){1'b0}}, lead};
      res.consumed   = Len1;
    end
    return res;
  endfunction

endpackage

FILE: design/utf8_decoder_core.sv
// UTF-8 decoder with validation. Each item is a window of four bytes taken at
// the current position of a string, plus the number of bytes left in the
// string (saturated at four; values above four count as four, zero as one).
// The block gives one result item per input item: the decoded scalar value
// and the number of bytes the sequence occupies, so that the caller can step
// its position by that amount. Bytes beyond the string end are ignored. A
// malformed sequence (stray continuation byte, a 5 or 6 byte lead, a form cut
// short by the string end, a missing continuation byte, an overlong form, a
// value above 0x10FFFF, or a surrogate) yields the lead byte itself as the
// code point with one byte consumed; plain ASCII decodes the same way. The
// block takes one item per clock cycle while the result side is not stalled:
// the window is captured in an input register, decoded by a single layer of
// compare and select logic, and held in a result register until taken.
// Results come out in input order, and the input side keeps accepting while a
// finished result waits, as long as the input register is empty.
module utf8_decoder_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [utf8d_pkg::ByteW-1:0]         lead_byte_i,
  input  logic [utf8d_pkg::ByteW-1:0]         second_byte_i,
  input  logic [utf8d_pkg::ByteW-1:0]         third_byte_i,
  input  logic [utf8d_pkg::ByteW-1:0]         fourth_byte_i,
  input  logic [utf8d_pkg::CountW-1:0]        bytes_left_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [utf8d_pkg::CodePointW-1:0]    code_point_o,
  output logic [utf8d_pkg::CountW-1:0]        consumed_o
);

  // Input register.
  logic                          in_valid_q;
  logic [utf8d_pkg::ByteW-1:0]   lead_q;
  logic [utf8d_pkg::ByteW-1:0]   second_q;
  logic [utf8d_pkg::ByteW-1:0]   third_q;
  logic [utf8d_pkg::ByteW-1:0]   fourth_q;
  logic [utf8d_pkg::CountW-1:0]  left_q;

  // Result register.
  logic                          out_valid_q;
  utf8d_pkg::result_t            res_q;
  utf8d_pkg::result_t            res_d;

  logic out_load;
  logic in_load;

  // The result register loads whenever it is empty or being drained; the
  // input register can then move forward, which frees it for a new item.
  assign out_load   = !out_valid_q || out_ready_i;
  assign in_load    = !in_valid_q || out_load;
  assign in_ready_o = in_load;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_load) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_load && in_valid_i) begin
      lead_q   <= lead_byte_i;
      second_q <= second_byte_i;
      third_q  <= third_byte_i;
      fourth_q <= fourth_byte_i;
      left_q   <= bytes_left_i;
    end
  end

  always_comb begin
    res_d = utf8d_pkg::decode(lead_q, second_q, third_q, fourth_q, left_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load && in_valid_q) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign code_point_o = res_q.code_point;
  assign consumed_o   = res_q.consumed;

endmodule

FILE: design/utf8d_checker.sv
`include "utf8_decoder_core_macros.svh"

module utf8d_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             in_ready_o,
  input logic                             out_valid_o,
  input logic                             out_ready_i,
  input logic [utf8d_pkg::CodePointW-1:0] code_point_o,
  input logic [utf8d_pkg::CountW-1:0]     consumed_o
);

  // Each sequence length covers its own value range.
  `UTF8D_ASSERT_IMP(a_len_range, out_valid_o,
    ((consumed_o == utf8d_pkg::Len1) && (code_point_o <= utf8d_pkg::MaxSingleByte)) ||
    ((consumed_o == utf8d_pkg::Len2) && (code_point_o >= utf8d_pkg::Min2ByteValue) &&
     (code_point_o < utf8d_pkg::Min3ByteValue)) ||
    ((consumed_o == utf8d_pkg::Len3) && (code_point_o >= utf8d_pkg::Min3ByteValue) &&
     (code_point_o < utf8d_pkg::Min4ByteValue)) ||
    ((consumed_o == utf8d_pkg::Len4) && (code_point_o >= utf8d_pkg::Min4ByteValue) &&
     (code_point_o <= utf8d_pkg::MaxCodePoint)),
    "utf8d: code point does not fit its sequence length")

  // A decoded multi-byte value is never a surrogate.
  `UTF8D_ASSERT_IMP(a_no_surrogate, out_valid_o && (consumed_o != utf8d_pkg::Len1),
    (code_point_o < utf8d_pkg::SurrogateLow) || (code_point_o > utf8d_pkg::SurrogateHigh),
    "utf8d: surrogate value decoded")

  // With the result side empty the pipeline can always advance.
  `UTF8D_ASSERT(a_ready_when_empty, out_valid_o || in_ready_o,
    "utf8d: input stalled while no result is pending")

  // A stalled result holds its value.
  `UTF8D_ASSERT_NEXT(a_hold_stalled, out_valid_o && !out_ready_i,
    out_valid_o && $stable(code_point_o) && $stable(consumed_o),
    "utf8d: stalled result changed")

endmodule

bind utf8_decoder_core utf8d_checker u_utf8d_checker (.*);

FILE: test/tb.sv
module tb;

  typedef logic [3:0][7:0] window_t;

  logic                                 clk = 1'b0;
  logic                                 rst_ni = 1'b0;
  logic                                 in_valid = 1'b0;
  logic                                 in_ready;
  logic [utf8d_pkg::ByteW-1:0]          lead_byte = '0;
  logic [utf8d_pkg::ByteW-1:0]          second_byte = '0;
  logic [utf8d_pkg::ByteW-1:0]          third_byte = '0;
  logic [utf8d_pkg::ByteW-1:0]          fourth_byte = '0;
  logic [utf8d_pkg::CountW-1:0]         bytes_left = 3'd1;
  logic                                 out_valid;
  logic                                 out_ready = 1'b0;
  logic [utf8d_pkg::CodePointW-1:0]     code_point;
  logic [utf8d_pkg::CountW-1:0]         consumed;

  // Decodes that the block still owes, oldest first.
  utf8d_pkg::result_t pending_decodes[$];
  utf8d_pkg::result_t oldest_decode;

  int  errors = 0;
  int  windows_sent = 0;
  int  results_seen = 0;
  int  multibyte_seen = 0;
  int  rejects_seen = 0;
  bit  idle_on = 1'b1;
  int  stall_left = 0;
  int  hold_off_left = 0;

  utf8_decoder_core dut (
    .clk_i         (clk),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .lead_byte_i   (lead_byte),
    .second_byte_i (second_byte),
    .third_byte_i  (third_byte),
    .fourth_byte_i (fourth_byte),
    .bytes_left_i  (bytes_left),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .code_point_o  (code_point),
    .consumed_o    (consumed)
  );

  always #4 clk = ~clk;

  // Expected decode of one window. Bytes past the string end are never looked
  // at, and any malformed sequence falls back to the lead byte alone.
  function automatic utf8d_pkg::result_t decode_window(input logic [7:0] lead,
                                                       input logic [7:0] b2,
                                                       input logic [7:0] b3,
                                                       input logic [7:0] b4,
                                                       input logic [2:0] left);
    logic [7:0]         tail [3];
    int                 avail;
    int                 form_len;
    int unsigned        value;
    int unsigned        floor_val;
    bit                 ok;
    utf8d_pkg::result_t res;
    tail[0] = b2;
    tail[1] = b3;
    tail[2] = b4;
    avail = (left > 3'd4) ? 4 : int'(left);
    res.code_point = {13'd0, lead};
    res.consumed   = 3'd1;
    if (lead[7]) begin
      form_len  = 0;
      value     = 0;
      floor_val = 0;
      casez (lead)
        8'b110?????: begin
          form_len  = 2;
          value     = lead[4:0];
          floor_val = 32'h80;
        end
        8'b1110????: begin
          form_len  = 3;
          value     = lead[3:0];
          floor_val = 32'h800;
        end
        8'b11110???: begin
          form_len  = 4;
          value     = lead[2:0];
          floor_val = 32'h10000;
        end
        default: form_len = 0;
      endcase
      ok = (form_len != 0) && (form_len <= avail);
      for (int i = 0; i < 3; i++) begin
        if (ok && i < form_len - 1) begin
          if (tail[i][7:6] != 2'b10) ok = 1'b0;
          else value = (value << 6) | tail[i][5:0];
        end
      end
      if (ok && (value < floor_val || value > 32'h10FFFF ||
                 (value >= 32'hD800 && value <= 32'hDFFF))) ok = 1'b0;
      if (ok) begin
        res.code_point = value[20:0];
        res.consumed   = form_len[2:0];
      end
    end
    return res;
  endfunction

  // Builds the UTF-8 form of a value in the given length, without checking
  // that the value fits or is legal, so overlong and out-of-range forms come
  // from the same place. Unused trailing bytes are random.
  function automatic window_t encode_form(input logic [20:0] cp, input int len);
    window_t w;
    w = {8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom)};
    case (len)
      1: w[0] = {1'b0, cp[6:0]};
      2: begin
        w[0] = {3'b110, cp[10:6]};
        w[1] = {2'b10, cp[5:0]};
      end
      3: begin
        w[0] = {4'b1110, cp[15:12]};
        w[1] = {2'b10, cp[11:6]};
        w[2] = {2'b10, cp[5:0]};
      end
      default: begin
        w[0] = {5'b11110, cp[20:18]};
        w[1] = {2'b10, cp[17:12]};
        w[2] = {2'b10, cp[11:6]};
        w[3] = {2'b10, cp[5:0]};
      end
    endcase
    return w;
  endfunction

  // A legal scalar value for a form of the given length.
  function automatic logic [20:0] legal_value(input int len);
    logic [20:0] cp;
    case (len)
      1: cp = 21'($urandom_range(0, 32'h7F));
      2: cp = 21'($urandom_range(32'h80, 32'h7FF));
      3: begin
        cp = 21'($urandom_range(32'h800, 32'hFFFF));
        // Move surrogates out of the way rather than drawing again.
        if (cp >= 21'hD800 && cp <= 21'hDFFF) cp = cp ^ 21'h4000;
      end
      default: cp = 21'($urandom_range(32'h10000, 32'h10FFFF));
    endcase
    return cp;
  endfunction

  // Offers one window and waits until the block takes it. A random gap may
  // come first while idling is on.
  task automatic send_window(input logic [7:0] lead, input logic [7:0] b2,
                             input logic [7:0] b3, input logic [7:0] b4,
                             input logic [2:0] left);
    int gap;
    gap = 0;
    if (idle_on && $urandom_range(0, 7) == 0) gap = $urandom_range(1, 19);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid    <= 1'b1;
    lead_byte   <= lead;
    second_byte <= b2;
    third_byte  <= b3;
    fourth_byte <= b4;
    bytes_left  <= left;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_decodes.push_back(decode_window(lead, b2, b3, b4, left));
    windows_sent++;
  endtask

  // Receiver: a long hold-off when one is asked for, otherwise random stall
  // bursts while idling is on.
  always @(negedge clk) begin
    if (hold_off_left > 0) begin
      hold_off_left = hold_off_left - 1;
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left = stall_left - 1;
      out_ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(1, 19) - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Every result taken is compared with the oldest pending decode.
  always @(posedge clk) begin
    if (rst_ni && out_valid && out_ready) begin
      if (pending_decodes.size() == 0) begin
        $display("%0t: result with nothing pending: code_point %h consumed %0d",
                 $time, code_point, consumed);
        errors++;
      end else begin
        oldest_decode = pending_decodes.pop_front();
        results_seen++;
        if (oldest_decode.consumed > 3'd1) multibyte_seen++;
        else if (oldest_decode.code_point >= 21'h80) rejects_seen++;
        if (code_point !== oldest_decode.code_point) begin
          $display("%0t: code_point mismatch: expected %h actual %h",
                   $time, oldest_decode.code_point, code_point);
          errors++;
        end
        if (consumed !== oldest_decode.consumed) begin
          $display("%0t: consumed mismatch: expected %0d actual %0d",
                   $time, oldest_decode.consumed, consumed);
          errors++;
        end
      end
    end
  end

  // Well-formed sequences of every length at their boundaries, plus the
  // saturation of the byte count at both ends.
  task automatic test_directed_forms();
    send_window(8'h00, 8'hFF, 8'hFF, 8'hFF, 3'd1);
    send_window(8'h7F, 8'h80, 8'h80, 8'h80, 3'd4);
    send_window(8'hC2, 8'h80, 8'h00, 8'h00, 3'd2);
    send_window(8'hDF, 8'hBF, 8'hFF, 8'hFF, 3'd4);
    send_window(8'hE0, 8'hA0, 8'h80, 8'h00, 3'd3);
    send_window(8'hEF, 8'hBF, 8'hBF, 8'hFF, 3'd4);
    send_window(8'hED, 8'h9F, 8'hBF, 8'h00, 3'd4);
    send_window(8'hF0, 8'h90, 8'h80, 8'h80, 3'd4);
    send_window(8'hF4, 8'h8F, 8'hBF, 8'hBF, 3'd4);
    // A count above four acts as four; zero acts as one.
    send_window(8'hF0, 8'h90, 8'h80, 8'h80, 3'd7);
    send_window(8'h41, 8'h00, 8'h00, 8'h00, 3'd0);
  endtask

  // One window for each way a sequence can be rejected.
  task automatic test_directed_errors();
    send_window(8'hC1, 8'hBF, 8'h00, 8'h00, 3'd4);   // overlong two-byte
    send_window(8'hE0, 8'h9F, 8'hBF, 8'h00, 3'd4);   // overlong three-byte
    send_window(8'hF0, 8'h8F, 8'hBF, 8'hBF, 3'd4);   // overlong four-byte
    send_window(8'hED, 8'hA0, 8'h80, 8'h00, 3'd4);   // lowest surrogate
    send_window(8'hED, 8'hBF, 8'hBF, 8'h00, 3'd4);   // highest surrogate
    send_window(8'hF4, 8'h90, 8'h80, 8'h80, 3'd4);   // just above range
    send_window(8'h80, 8'h80, 8'h80, 8'h80, 3'd4);   // stray continuation
    send_window(8'hF8, 8'h88, 8'h80, 8'h80, 3'd4);   // five-byte lead
    send_window(8'hFC, 8'h84, 8'h80, 8'h80, 3'd4);   // six-byte lead
    send_window(8'hE0, 8'hA0, 8'h80, 8'h00, 3'd2);   // cut short by the end
    send_window(8'hF0, 8'h90, 8'h80, 8'h80, 3'd3);   // cut short by the end
    send_window(8'hC2, 8'h80, 8'h00, 8'h00, 3'd0);   // zero count, multi-byte
    send_window(8'hC2, 8'h41, 8'h00, 8'h00, 3'd4);   // second byte not a tail
    send_window(8'hE2, 8'h82, 8'hC0, 8'h00, 3'd4);   // third byte not a tail
    send_window(8'hF0, 8'h90, 8'h80, 8'h7F, 3'd4);   // fourth byte not a tail
    send_window(8'hFF, 8'hFF, 8'hFF, 8'hFF, 3'd4);
  endtask

  // Mostly well-formed text with random content; the rest is broken on
  // purpose in each of the ways the decoder checks, or is plain noise.
  task automatic test_random_mix(input int count);
    window_t     w;
    logic [2:0]  left;
    logic [20:0] cp;
    int          len;
    int          pick;
    int          k;
    int          top;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      len  = $urandom_range(2, 4);
      left = 3'd4;
      if (pick < 55) begin
        len  = $urandom_range(1, 4);
        w    = encode_form(legal_value(len), len);
        left = 3'($urandom_range(len, 4));
      end else if (pick < 63) begin
        w    = encode_form(legal_value(len), len);
        left = 3'($urandom_range(1, len - 1));
      end else if (pick < 71) begin
        w   = encode_form(legal_value(len), len);
        k   = $urandom_range(1, len - 1);
        top = $urandom_range(0, 2);
        w[k][7:6] = (top == 0) ? 2'b00 : (top == 1) ? 2'b01 : 2'b11;
      end else if (pick < 77) begin
        if (len == 2) cp = 21'($urandom_range(0, 32'h7F));
        else if (len == 3) cp = 21'($urandom_range(0, 32'h7FF));
        else cp = 21'($urandom_range(0, 32'hFFFF));
        w = encode_form(cp, len);
      end else if (pick < 82) begin
        w = encode_form(21'($urandom_range(32'hD800, 32'hDFFF)), 3);
      end else if (pick < 86) begin
        w = encode_form(21'($urandom_range(32'h110000, 32'h1FFFFF)), 4);
      end else if (pick < 90) begin
        w = encode_form(21'd0, 4);
        if ($urandom_range(0, 1) == 0) w[0] = {2'b10, 6'($urandom)};
        else w[0] = {5'b11111, 3'($urandom)};
      end else begin
        w    = {8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom)};
        left = 3'($urandom_range(1, 4));
      end
      send_window(w[0], w[1], w[2], w[3], left);
    end
  endtask

  // The receiver holds off for a long stretch while windows keep coming
  // back to back, so the block fills and has to stall its input.
  task automatic test_input_stall();
    idle_on = 1'b0;
    @(negedge clk);
    // The last window is already taken, so it must not stay on offer.
    in_valid <= 1'b0;
    hold_off_left = 300;
    test_random_mix(40);
    idle_on = 1'b1;
  endtask

  initial begin
    repeat (6) @(negedge clk);
    rst_ni <= 1'b1;

    test_directed_forms();
    test_directed_errors();
    test_random_mix(700);
    test_input_stall();
    // The last stretch runs at full rate on both sides.
    idle_on = 1'b0;
    test_random_mix(160);

    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_decodes.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("Decoded %0d windows and checked %0d results.", windows_sent, results_seen);
    $display("Of those, %0d were multi-byte scalars and %0d were rejected sequences.",
             multibyte_seen, rejects_seen);
    if (errors == 0) begin
      $display("utf8_decoder_core test passed");
    end else begin
      $display("utf8_decoder_core test failed");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("Timed out with %0d decodes still pending.", pending_decodes.size());
    $display("utf8_decoder_core test failed");
    $finish;
  end

endmodule
